/* design/lss_pkg.sv */
// Shared types and constants for the lidar scan segmenter.
package lss_pkg;

    // Field widths
    localparam int AZ_W   = 16;
    localparam int TIME_W = 63;
    localparam int ID_W   = 32;
    localparam int SIZE_W = 16;
    localparam int GAP_W  = 24;
    localparam int MISS_W = 8;
    localparam int TGAP_W = 32;
    localparam int QUOT_W = 17;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [AZ_W-1:0]   FULL_TURN = 16'd36000;
    localparam logic [GAP_W-1:0]  GAP_MAX   = 24'hFF_FFFF;
    localparam logic [SIZE_W-1:0] SIZE_MAX  = 16'hFFFF;

    // Register indexes (paddr[2])
    localparam logic [0:0] REG_MAX_MISSING  = 1'b0;
    localparam logic [0:0] REG_MAX_TIME_GAP = 1'b1;

    localparam logic [MISS_W-1:0] MAX_MISSING_RST  = 8'd1;
    localparam logic [TGAP_W-1:0] MAX_TIME_GAP_RST = 32'd1200;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RECIP,
        S_SCALE,
        S_UPDATE
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic recip;
        logic scale;
        logic commit;
    } cmd_t;

endpackage

/* design/lss_ctrl.sv */
// Sequencing controller: input/output handshakes and per-beat step commands.
module lss_ctrl
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    output logic          out_valid,
    input  logic          out_ready,
    output lss_pkg::cmd_t cmd
);

    lss_pkg::state_t state_reg;
    lss_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;

    // State and output-valid registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= lss_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            lss_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = lss_pkg::S_RECIP;
                end
            end
            lss_pkg::S_RECIP:
            begin
                cmd.recip  = 1'b1;
                state_next = lss_pkg::S_SCALE;
            end
            lss_pkg::S_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = lss_pkg::S_UPDATE;
            end
            lss_pkg::S_UPDATE:
            begin
                // Hold until the result register is free
                if (!out_valid_reg || out_ready)
                begin
                    cmd.commit = 1'b1;
                    state_next = lss_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = lss_pkg::S_IDLE;
            end
        endcase
    end

    // Load result beat on commit, drop it once taken
    always_comb
    begin
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

`ifndef SYNTHESIS
    a_accept_to_scale: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##2 state_reg == lss_pkg::S_SCALE)
        else $error("accepted beat did not reach scale step");

    a_update_stall: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == lss_pkg::S_UPDATE && out_valid_reg && !out_ready
        |=> state_reg == lss_pkg::S_UPDATE)
        else $error("update left while result register full");

    a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> out_valid_reg && state_reg == lss_pkg::S_IDLE)
        else $error("commit did not present a result beat");
`endif

endmodule

/* design/lss_datapath.sv */
// Datapath: angle gap estimate, time gap test and scan state update.
module lss_datapath
#(
    parameter int BLOCKS = 12
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  lss_pkg::cmd_t                 cmd,
    input  logic [lss_pkg::MISS_W-1:0]    max_missing_packets,
    input  logic [lss_pkg::TGAP_W-1:0]    max_time_gap_us,
    input  logic [lss_pkg::AZ_W-1:0]      first_azimuth,
    input  logic [lss_pkg::AZ_W-1:0]      last_azimuth,
    input  logic                          time_valid,
    input  logic [lss_pkg::TIME_W-1:0]    timestamp_us,
    output logic [lss_pkg::ID_W-1:0]      scan_id,
    output logic [lss_pkg::AZ_W-1:0]      scan_begin,
    output logic [lss_pkg::AZ_W-1:0]      scan_end,
    output logic [lss_pkg::SIZE_W-1:0]    scan_size,
    output logic                          new_scan,
    output logic                          scan_complete,
    output logic                          gap_unset
);

    // Reciprocal multiply for division by BLOCKS-1, exact for all x < 2^XW
    localparam int BW  = $clog2(BLOCKS);
    localparam int XW  = lss_pkg::AZ_W + BW;
    localparam int K   = XW + BW;
    localparam int DIV = BLOCKS - 1;
    localparam int MW  = K + 1;
    localparam int PW  = XW + MW;
    localparam logic [MW-1:0] RECIP = MW'(((64'd1 << K) / DIV) + 64'd1);
    localparam int GW  = lss_pkg::QUOT_W + lss_pkg::MISS_W;

    // Per-beat working registers
    logic [lss_pkg::AZ_W-1:0]     first_reg;
    logic [XW-1:0]                x_reg;
    logic                         wrap_reg;
    logic                         tvalid_reg;
    logic [lss_pkg::TIME_W-1:0]   ts_reg;
    logic [lss_pkg::TIME_W-1:0]   tdiff_reg;
    logic                         tahead_reg;
    logic [lss_pkg::QUOT_W-1:0]   q_reg;
    logic                         time_gap_reg;
    logic [lss_pkg::GAP_W-1:0]    gap_reg;

    // Scan state
    logic [lss_pkg::ID_W-1:0]     cur_id_reg;
    logic [lss_pkg::AZ_W-1:0]     cur_begin_reg;
    logic [lss_pkg::AZ_W-1:0]     cur_end_reg;
    logic [lss_pkg::SIZE_W-1:0]   cur_size_reg;
    logic [lss_pkg::TIME_W-1:0]   last_time_reg;
    logic                         last_valid_reg;
    logic                         new_scan_reg;
    logic                         complete_reg;
    logic                         gap_unset_reg;

    // Load-step logic
    logic [lss_pkg::AZ_W:0]       turn_sum;
    logic [lss_pkg::AZ_W+1:0]     wrap_diff;
    logic [lss_pkg::AZ_W-1:0]     d_span;
    logic [lss_pkg::TIME_W:0]     tdiff_full;

    // Reciprocal and scale steps
    logic [PW-1:0]                prod;
    logic [GW-1:0]                gap_prod;
    logic                         time_gap;
    logic [lss_pkg::GAP_W-1:0]    gap_next;

    // Commit-step logic
    logic [lss_pkg::AZ_W-1:0]     step;
    logic                         backward;
    logic                         too_far;
    logic                         no_scan;
    logic                         open_scan;
    logic [lss_pkg::AZ_W-1:0]     span_ext;
    logic [lss_pkg::AZ_W-1:0]     remain_ext;
    logic                         complete_ext;
    logic                         complete_open;

    // Unwrap the packet span; flag spans whose unwrapped difference goes negative
    always_comb
    begin
        turn_sum   = {1'b0, last_azimuth} + {1'b0, lss_pkg::FULL_TURN};
        wrap_diff  = {1'b0, turn_sum} - {2'b00, first_azimuth};
        if (last_azimuth >= first_azimuth)
        begin
            d_span = last_azimuth - first_azimuth;
        end
        else
        begin
            d_span = wrap_diff[lss_pkg::AZ_W-1:0];
        end
        tdiff_full = {1'b0, timestamp_us} - {1'b0, last_time_reg};
    end

    // Capture the beat
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            first_reg  <= first_azimuth;
            x_reg      <= XW'(d_span) * XW'(BLOCKS);
            wrap_reg   <= (last_azimuth < first_azimuth) && wrap_diff[lss_pkg::AZ_W+1];
            tvalid_reg <= time_valid;
            ts_reg     <= timestamp_us;
            tdiff_reg  <= tdiff_full[lss_pkg::TIME_W-1:0];
            tahead_reg <= !tdiff_full[lss_pkg::TIME_W];
        end
    end

    // Divide by BLOCKS-1 and test the time gap
    always_comb
    begin
        prod     = PW'(x_reg) * PW'(RECIP);
        time_gap = tvalid_reg && last_valid_reg && tahead_reg &&
                   ((|tdiff_reg[lss_pkg::TIME_W-1:lss_pkg::TGAP_W]) ||
                    (tdiff_reg[lss_pkg::TGAP_W-1:0] > max_time_gap_us));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.recip)
        begin
            q_reg        <= prod[K +: lss_pkg::QUOT_W];
            time_gap_reg <= time_gap;
        end
    end

    // Scale by tolerated missing packets and saturate
    always_comb
    begin
        gap_prod = GW'(q_reg) * GW'(max_missing_packets);
        if (max_missing_packets == '0)
        begin
            gap_next = '0;
        end
        else if (wrap_reg || (|gap_prod[GW-1:lss_pkg::GAP_W]))
        begin
            gap_next = lss_pkg::GAP_MAX;
        end
        else
        begin
            gap_next = gap_prod[lss_pkg::GAP_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.scale)
        begin
            gap_reg <= gap_next;
        end
    end

    // Decide between opening and extending a scan
    always_comb
    begin
        step          = first_reg - cur_end_reg;
        backward      = first_reg < cur_end_reg;
        too_far       = {{(lss_pkg::GAP_W-lss_pkg::AZ_W){1'b0}}, step} > gap_reg;
        no_scan       = cur_size_reg == '0;
        open_scan     = no_scan || time_gap_reg || backward || too_far;
        span_ext      = first_reg - cur_begin_reg;
        remain_ext    = lss_pkg::FULL_TURN - span_ext;
        complete_ext  = (first_reg >= cur_begin_reg) && (span_ext <= lss_pkg::FULL_TURN) &&
                        ({{(lss_pkg::GAP_W-lss_pkg::AZ_W){1'b0}}, remain_ext} < gap_reg);
        complete_open = {{(lss_pkg::GAP_W-lss_pkg::AZ_W){1'b0}}, lss_pkg::FULL_TURN} < gap_reg;
    end

    // Advance scan state and result flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_id_reg     <= '0;
            cur_begin_reg  <= '0;
            cur_end_reg    <= '0;
            cur_size_reg   <= '0;
            last_time_reg  <= '0;
            last_valid_reg <= 1'b0;
            new_scan_reg   <= 1'b0;
            complete_reg   <= 1'b0;
            gap_unset_reg  <= 1'b0;
        end
        else if (cmd.commit)
        begin
            cur_end_reg   <= first_reg;
            new_scan_reg  <= open_scan;
            gap_unset_reg <= gap_reg == '0;
            if (open_scan)
            begin
                cur_begin_reg <= first_reg;
                cur_size_reg  <= lss_pkg::SIZE_W'(1);
                complete_reg  <= complete_open;
                if (!no_scan)
                begin
                    cur_id_reg <= cur_id_reg + lss_pkg::ID_W'(1);
                end
            end
            else
            begin
                complete_reg <= complete_ext;
                if (cur_size_reg != lss_pkg::SIZE_MAX)
                begin
                    cur_size_reg <= cur_size_reg + lss_pkg::SIZE_W'(1);
                end
            end
            if (tvalid_reg)
            begin
                last_time_reg  <= ts_reg;
                last_valid_reg <= 1'b1;
            end
        end
    end

    assign scan_id       = cur_id_reg;
    assign scan_begin    = cur_begin_reg;
    assign scan_end      = cur_end_reg;
    assign scan_size     = cur_size_reg;
    assign new_scan      = new_scan_reg;
    assign scan_complete = complete_reg;
    assign gap_unset     = gap_unset_reg;

`ifndef SYNTHESIS
    a_end_after_begin: assert property (@(posedge clk) disable iff (!rst_n)
        cur_end_reg >= cur_begin_reg)
        else $error("scan end fell behind scan begin");

    a_size_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> cur_size_reg != '0)
        else $error("scan size zero after a committed packet");
`endif

endmodule

/* design/lidar_scan_segmenter.sv */
// Top level: configuration registers, controller and datapath.
//
//  channel | signals                                            | direction
//  --------+----------------------------------------------------+----------
//  in      | in_valid/in_ready, first_azimuth, last_azimuth,    | to block
//          | time_valid, timestamp_us                           |
//  out     | out_valid/out_ready, scan_id, scan_begin, scan_end,| from block
//          | scan_size, new_scan, scan_complete, gap_unset      |
//  cfg     | psel, penable, pwrite, paddr, pwdata, prdata,      | APB slave
//          | pready                                             |
//
// A packet passes through capture, divide-by-reciprocal multiply, gap scaling
// multiply and scan update in turn; the two multiplies are chained.
// in_ready is high only while the sequencer is idle; a result beat waiting in
// the output register does not block the next capture, only the next update.
// Reset clears scan state, last timestamp and the registers to 1 and 1200.
module lidar_scan_segmenter
#(
    parameter int BLOCKS = 12
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [lss_pkg::AZ_W-1:0]       first_azimuth,
    input  logic [lss_pkg::AZ_W-1:0]       last_azimuth,
    input  logic                           time_valid,
    input  logic [lss_pkg::TIME_W-1:0]     timestamp_us,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [lss_pkg::ID_W-1:0]       scan_id,
    output logic [lss_pkg::AZ_W-1:0]       scan_begin,
    output logic [lss_pkg::AZ_W-1:0]       scan_end,
    output logic [lss_pkg::SIZE_W-1:0]     scan_size,
    output logic                           new_scan,
    output logic                           scan_complete,
    output logic                           gap_unset,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [lss_pkg::ADDR_W-1:0]     paddr,
    input  logic [lss_pkg::DATA_W-1:0]     pwdata,
    output logic [lss_pkg::DATA_W-1:0]     prdata,
    output logic                           pready
);

    logic [lss_pkg::MISS_W-1:0] max_missing_reg;
    logic [lss_pkg::TGAP_W-1:0] max_time_gap_reg;
    logic                       cfg_write;
    lss_pkg::cmd_t              cmd;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    // Configuration register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_missing_reg  <= lss_pkg::MAX_MISSING_RST;
            max_time_gap_reg <= lss_pkg::MAX_TIME_GAP_RST;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                lss_pkg::REG_MAX_MISSING:
                begin
                    max_missing_reg <= pwdata[lss_pkg::MISS_W-1:0];
                end
                lss_pkg::REG_MAX_TIME_GAP:
                begin
                    max_time_gap_reg <= pwdata[lss_pkg::TGAP_W-1:0];
                end
                default:
                begin
                    max_missing_reg <= max_missing_reg;
                end
            endcase
        end
    end

    // Register read mux
    always_comb
    begin
        unique case (paddr[2])
            lss_pkg::REG_MAX_MISSING:
            begin
                prdata = lss_pkg::DATA_W'(max_missing_reg);
            end
            lss_pkg::REG_MAX_TIME_GAP:
            begin
                prdata = lss_pkg::DATA_W'(max_time_gap_reg);
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    lss_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    lss_datapath
    #(
        .BLOCKS (BLOCKS)
    )
    u_datapath
    (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .max_missing_packets (max_missing_reg),
        .max_time_gap_us     (max_time_gap_reg),
        .first_azimuth       (first_azimuth),
        .last_azimuth        (last_azimuth),
        .time_valid          (time_valid),
        .timestamp_us        (timestamp_us),
        .scan_id             (scan_id),
        .scan_begin          (scan_begin),
        .scan_end            (scan_end),
        .scan_size           (scan_size),
        .new_scan            (new_scan),
        .scan_complete       (scan_complete),
        .gap_unset           (gap_unset)
    );

endmodule

/* tb/tb_lidar_scan_segmenter.sv */
// Self-checking testbench for the lidar scan segmenter: directed and random packets, scoreboard.
`timescale 1ns / 1ps

typedef struct packed {
    logic [lss_pkg::ID_W-1:0]   id;
    logic [lss_pkg::AZ_W-1:0]   start_az;
    logic [lss_pkg::AZ_W-1:0]   end_az;
    logic [lss_pkg::SIZE_W-1:0] size;
    logic                       opened;
    logic                       complete;
    logic                       unset;
} scan_report_t;

// Tracks the scan that the block should be building and the reports it should give
class scan_tracker #(int BLOCKS = 12);
    logic [lss_pkg::MISS_W-1:0] miss_limit;
    logic [lss_pkg::TGAP_W-1:0] time_limit;
    logic [lss_pkg::ID_W-1:0]   scan_no;
    logic [lss_pkg::AZ_W-1:0]   scan_start;
    logic [lss_pkg::AZ_W-1:0]   scan_last;
    logic [lss_pkg::SIZE_W-1:0] scan_len;
    logic [lss_pkg::TIME_W-1:0] prev_ts;
    logic                       prev_ts_ok;
    scan_report_t               expected_reports[$];
    int                         errors;

    function new();
        miss_limit = lss_pkg::MAX_MISSING_RST;
        time_limit = lss_pkg::MAX_TIME_GAP_RST;
        scan_no    = '0;
        scan_start = '0;
        scan_last  = '0;
        scan_len   = '0;
        prev_ts    = '0;
        prev_ts_ok = 1'b0;
        errors     = 0;
    endfunction

    function void set_reg(logic [0:0] index, logic [lss_pkg::DATA_W-1:0] value);
        if (index == lss_pkg::REG_MAX_MISSING)
            miss_limit = value[lss_pkg::MISS_W-1:0];
        else
            time_limit = value;
    endfunction

    function int pending();
        return expected_reports.size();
    endfunction

    // Tolerated forward step: packet extent scaled to a full packet, times missing packets
    function logic [lss_pkg::GAP_W-1:0] allowed_gap(logic [lss_pkg::AZ_W-1:0] first_az,
                                                     logic [lss_pkg::AZ_W-1:0] last_az);
        logic [31:0] stop;
        logic [63:0] scaled;
        stop = {16'd0, last_az};
        if (last_az < first_az)
            stop = stop + {16'd0, lss_pkg::FULL_TURN};
        scaled = {32'd0, stop - {16'd0, first_az}};
        scaled = scaled * 64'(BLOCKS) / 64'(BLOCKS - 1);
        scaled = scaled * {56'd0, miss_limit};
        if (scaled > {40'd0, lss_pkg::GAP_MAX})
            return lss_pkg::GAP_MAX;
        return scaled[lss_pkg::GAP_W-1:0];
    endfunction

    // Advance the scan state by one accepted packet and queue its report
    function void note_packet(logic [lss_pkg::AZ_W-1:0] first_az,
                              logic [lss_pkg::AZ_W-1:0] last_az,
                              logic tv, logic [lss_pkg::TIME_W-1:0] ts);
        logic [lss_pkg::GAP_W-1:0] gap;
        logic                      late;
        logic [31:0]               span;
        scan_report_t              r;
        gap  = allowed_gap(first_az, last_az);
        late = tv && prev_ts_ok && ts > prev_ts && (ts - prev_ts) > {31'd0, time_limit};
        r.opened = 1'b1;
        if (scan_len == '0)
        begin
            scan_start = first_az;
            scan_last  = first_az;
            scan_len   = 16'd1;
        end
        else if (late || first_az < scan_last || {8'd0, first_az - scan_last} > gap)
        begin
            scan_no    = scan_no + 32'd1;
            scan_start = first_az;
            scan_last  = first_az;
            scan_len   = 16'd1;
        end
        else
        begin
            r.opened  = 1'b0;
            scan_last = first_az;
            if (scan_len != lss_pkg::SIZE_MAX)
                scan_len = scan_len + 16'd1;
        end
        if (tv)
        begin
            prev_ts    = ts;
            prev_ts_ok = 1'b1;
        end
        // A span wider than a turn only arises from out-of-range azimuths: never complete
        span = {16'd0, scan_last} - {16'd0, scan_start};
        r.complete = gap != '0 && scan_last >= scan_start && span <= 32'd36000 &&
                     (32'd36000 - span) < {8'd0, gap};
        r.unset    = (gap == '0);
        r.id       = scan_no;
        r.start_az = scan_start;
        r.end_az   = scan_last;
        r.size     = scan_len;
        expected_reports.push_back(r);
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endfunction

    // Compare one result beat against the oldest queued report
    function void check_report(scan_report_t got);
        scan_report_t want;
        if (expected_reports.size() == 0)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: result beat with none pending, expected none, actual id %0d",
                         $time, got.id);
            return;
        end
        want = expected_reports.pop_front();
        check_field("scan_id", want.id, got.id);
        check_field("scan_begin", 32'(want.start_az), 32'(got.start_az));
        check_field("scan_end", 32'(want.end_az), 32'(got.end_az));
        check_field("scan_size", 32'(want.size), 32'(got.size));
        check_field("new_scan", 32'(want.opened), 32'(got.opened));
        check_field("scan_complete", 32'(want.complete), 32'(got.complete));
        check_field("gap_unset", 32'(want.unset), 32'(got.unset));
    endfunction
endclass

module tb_lidar_scan_segmenter;

    localparam int BLOCKS      = 12;
    localparam int CYCLE_LIMIT = 2000000;
    localparam logic [lss_pkg::TIME_W-1:0] TS_MAX = '1;

    logic                          clk           = 1'b0;
    logic                          rst_n         = 1'b0;
    logic                          in_valid      = 1'b0;
    logic                          in_ready;
    logic [lss_pkg::AZ_W-1:0]      first_azimuth = '0;
    logic [lss_pkg::AZ_W-1:0]      last_azimuth  = '0;
    logic                          time_valid    = 1'b0;
    logic [lss_pkg::TIME_W-1:0]    timestamp_us  = '0;
    logic                          out_valid;
    logic                          out_ready     = 1'b0;
    logic [lss_pkg::ID_W-1:0]      scan_id;
    logic [lss_pkg::AZ_W-1:0]      scan_begin;
    logic [lss_pkg::AZ_W-1:0]      scan_end;
    logic [lss_pkg::SIZE_W-1:0]    scan_size;
    logic                          new_scan;
    logic                          scan_complete;
    logic                          gap_unset;
    logic                          psel          = 1'b0;
    logic                          penable       = 1'b0;
    logic                          pwrite        = 1'b0;
    logic [lss_pkg::ADDR_W-1:0]    paddr         = '0;
    logic [lss_pkg::DATA_W-1:0]    pwdata        = '0;
    logic [lss_pkg::DATA_W-1:0]    prdata;
    logic                          pready;

    scan_tracker #(BLOCKS)         tracker;
    scan_report_t                  seen_report;
    bit                            idle_mode   = 1'b0;
    int                            stall_left  = 0;
    int                            cycles      = 0;
    int                            sweep_az    = 0;
    int                            sweep_width = 1000;
    logic [lss_pkg::TIME_W-1:0]    sweep_ts    = '0;

    lidar_scan_segmenter #(.BLOCKS(BLOCKS)) uut (.*);

    always #5 clk = ~clk;

    // Stall the result side in random bursts while idling is on
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (idle_mode && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 8);
            out_ready  <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
        end
    end

    // Check result beats and record packet beats as they are accepted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                seen_report.id       = scan_id;
                seen_report.start_az = scan_begin;
                seen_report.end_az   = scan_end;
                seen_report.size     = scan_size;
                seen_report.opened   = new_scan;
                seen_report.complete = scan_complete;
                seen_report.unset    = gap_unset;
                tracker.check_report(seen_report);
            end
            if (in_valid && in_ready)
                tracker.note_packet(first_azimuth, last_azimuth, time_valid, timestamp_us);
        end
    end

    // Give up on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Present one packet beat and hold it until accepted
    task automatic send_packet(input logic [lss_pkg::AZ_W-1:0] first_az,
                               input logic [lss_pkg::AZ_W-1:0] last_az,
                               input logic tv, input logic [lss_pkg::TIME_W-1:0] ts);
        in_valid      <= 1'b1;
        first_azimuth <= first_az;
        last_azimuth  <= last_az;
        time_valid    <= tv;
        timestamp_us  <= ts;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic pause_sender(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Hold off new packets until every queued report has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (tracker.pending() != 0)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [0:0] index, input logic [lss_pkg::DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        tracker.set_reg(index, value);
        @(posedge clk);
    endtask

    // Random packets: mostly a sweeping rotor with lost packets, jumps and time glitches
    task automatic stream_packets(input int count);
        int                         i;
        int                         kind;
        int                         skips;
        logic [lss_pkg::AZ_W-1:0]   first_az;
        logic [lss_pkg::AZ_W-1:0]   last_az;
        logic                       tv;
        logic [lss_pkg::TIME_W-1:0] ts;
        sweep_width = $urandom_range(150, 1800);
        if ($urandom_range(0, 1) == 1)
            sweep_ts = lss_pkg::TIME_W'({$urandom, $urandom});
        for (i = 0; i < count; i++)
        begin
            kind  = $urandom_range(0, 99);
            skips = 0;
            tv    = 1'b1;
            if (kind < 8)
            begin
                // noise: any value of any field
                first_az = lss_pkg::AZ_W'($urandom);
                last_az  = lss_pkg::AZ_W'($urandom);
                tv       = 1'($urandom);
                ts       = lss_pkg::TIME_W'({$urandom, $urandom});
            end
            else
            begin
                if (kind < 12)
                begin
                    sweep_az    = $urandom_range(0, 35999);
                    sweep_width = $urandom_range(150, 1800);
                end
                else if (kind < 28)
                begin
                    skips = $urandom_range(1, 4);
                end
                first_az = lss_pkg::AZ_W'(sweep_az);
                last_az  = lss_pkg::AZ_W'((sweep_az + sweep_width + $urandom_range(0, 10) - 5)
                                          % 36000);
                // repeat the azimuth now and then, else step one packet plus lost ones
                if (kind >= 28 && kind < 33)
                begin
                end
                else
                begin
                    sweep_az = sweep_az + sweep_width * BLOCKS / (BLOCKS - 1) * (skips + 1)
                               - $urandom_range(0, 10);
                    if (sweep_az >= 36000)
                        sweep_az = sweep_az - 36000;
                end
                if (kind >= 33 && kind < 38)
                    sweep_ts = sweep_ts + lss_pkg::TIME_W'($urandom_range(1000, 200000));
                else
                    sweep_ts = sweep_ts + lss_pkg::TIME_W'($urandom_range(20, 600) * (skips + 1));
                ts = sweep_ts;
                if (kind >= 38 && kind < 43)
                begin
                    tv = 1'b0;
                    ts = lss_pkg::TIME_W'({$urandom, $urandom});
                end
                else if (kind >= 43 && kind < 46)
                begin
                    ts = sweep_ts - lss_pkg::TIME_W'($urandom_range(1, 5000));
                end
            end
            send_packet(first_az, last_az, tv, ts);
            if (kind == 99)
                drain();
            else if (idle_mode && $urandom_range(0, 3) == 0)
                pause_sender($urandom_range(1, 9));
        end
    endtask

    initial
    begin
        tracker = new();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed packets at reset settings
        send_packet(16'd0, 16'd1000, 1'b1, 63'd0);          // very first scan
        send_packet(16'd1000, 16'd2000, 1'b1, 63'd100);     // step within the gap
        send_packet(16'd1000, 16'd2000, 1'b1, 63'd200);     // zero step
        send_packet(16'd500, 16'd1500, 1'b1, 63'd300);      // backward step
        send_packet(16'd1500, 16'd2500, 1'b1, 63'd1501);    // time gap just over the limit
        send_packet(16'd2500, 16'd3500, 1'b1, 63'd2701);    // time gap at the limit
        send_packet(16'd3500, 16'd4500, 1'b1, 63'd5);       // timestamp going back
        send_packet(16'd4500, 16'd5500, 1'b0, TS_MAX);      // timestamp not valid
        send_packet(16'd5500, 16'd6500, 1'b1, TS_MAX);      // largest time jump
        send_packet(16'd35000, 16'd500, 1'b1, TS_MAX);      // packet across north
        send_packet(16'd35999, 16'd35999, 1'b0, 63'd0);     // zero extent: gap unset
        send_packet(16'd35999, 16'd35998, 1'b0, 63'd0);     // near full-turn extent
        send_packet(16'd0, 16'd35999, 1'b0, 63'd0);
        send_packet(16'd35999, 16'd0, 1'b0, 63'd0);
        send_packet(16'hFFFF, 16'd0, 1'b1, 63'd0);          // out-of-range azimuth
        send_packet(16'd40000, 16'd45000, 1'b1, 63'd0);
        send_packet(16'd45000, 16'd40000, 1'b0, 63'd0);
        drain();

        // Widest tolerances
        write_reg(lss_pkg::REG_MAX_MISSING, 32'd255);
        write_reg(lss_pkg::REG_MAX_TIME_GAP, 32'hFFFF_FFFF);
        send_packet(16'd0, 16'd1000, 1'b1, 63'd0);
        send_packet(16'd50000, 16'd55000, 1'b1, 63'd100);   // span wider than a turn
        send_packet(16'hFFFF, 16'hFFFF, 1'b1, TS_MAX);
        idle_mode = 1'b1;
        stream_packets(200);
        drain();

        // No tolerance at all
        write_reg(lss_pkg::REG_MAX_MISSING, 32'd0);
        write_reg(lss_pkg::REG_MAX_TIME_GAP, 32'd0);
        stream_packets(150);
        drain();

        // Back to the defaults, then a stretch without idling
        write_reg(lss_pkg::REG_MAX_MISSING, 32'd1);
        write_reg(lss_pkg::REG_MAX_TIME_GAP, 32'd1200);
        stream_packets(150);
        idle_mode = 1'b0;
        stream_packets(100);
        drain();

        write_reg(lss_pkg::REG_MAX_MISSING, lss_pkg::DATA_W'($urandom_range(2, 8)));
        write_reg(lss_pkg::REG_MAX_TIME_GAP, lss_pkg::DATA_W'($urandom_range(300, 5000)));
        idle_mode = 1'b1;
        stream_packets(250);
        drain();

        // Final stretch, no idling on either side
        idle_mode = 1'b0;
        write_reg(lss_pkg::REG_MAX_MISSING, 32'd2);
        write_reg(lss_pkg::REG_MAX_TIME_GAP, $urandom);
        stream_packets(300);
        drain();
        repeat (20) @(posedge clk);

        if (tracker.errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
